FILE: hdl/flash_write_packer_core_assert.svh
// Assertion macros for the flash write packer core.
`ifndef FLASH_WRITE_PACKER_CORE_ASSERT_SVH
`define FLASH_WRITE_PACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FWP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fwp assertion failed");
`define FWP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("fwp assertion failed");
`else
`define FWP_ASSERT(label, clk, rst_n, prop)
`define FWP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hdl/fwp_pkg.sv
// Shared constants and types for the flash write packer.
package fwp_pkg;

    localparam int WORD_BYTES = 8;
    localparam int PAGE_BYTES = 2048;

    localparam int PAGE_W  = $clog2(PAGE_BYTES);
    localparam int PNUM_W  = 32 - PAGE_W;
    localparam int CNT_W   = $clog2(WORD_BYTES + 1);
    localparam int IDX_W   = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

    localparam logic [7:0] BYTE_PAD = 8'hFF;

    localparam logic [1:0] FUNC_BEGIN  = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;
    localparam logic [1:0] FUNC_ABORT  = 2'd3;

    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_ERASE   = 2'd1;
    localparam logic [1:0] CMD_PROGRAM = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_STARTED = 2'd1;
    localparam logic [1:0] ST_MISALIGNED  = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] flash_address;
        logic [63:0] word_data;
        logic [1:0]  status;
        logic        last;
    } t_res;

    typedef struct packed {
        logic room_one;
        logic room_two;
    } t_room;

endpackage

FILE: hdl/fwp_engine.sv
// Session state and per-item command generation.
`include "flash_write_packer_core_assert.svh"

module fwp_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [1:0]    i_func,
    input  logic [31:0]   i_start,
    input  logic [7:0]    i_byte,
    output fwp_pkg::t_res o_res0,
    output fwp_pkg::t_res o_res1,
    output logic          o_two
);

    logic                           r_on;
    logic                           n_on;
    logic [31:0]                    r_cursor;
    logic [31:0]                    n_cursor;
    logic [fwp_pkg::PNUM_W-1:0]     r_page;
    logic [fwp_pkg::PNUM_W-1:0]     n_page;
    logic [fwp_pkg::CNT_W-1:0]      r_count;
    logic [fwp_pkg::CNT_W-1:0]      n_count;
    logic [7:0]                     r_bytes [fwp_pkg::WORD_BYTES];

    logic [31:0]                    wr_addr;
    logic [fwp_pkg::PNUM_W-1:0]     wr_page;
    logic                           need_erase;
    logic                           full;
    logic                           store;
    logic [63:0]                    w_full;
    logic [63:0]                    w_pad;
    fwp_pkg::t_res                  erase_res;
    fwp_pkg::t_res                  prog_res;

    assign wr_addr    = r_cursor + 32'(r_count);
    assign wr_page    = wr_addr[31:fwp_pkg::PAGE_W];
    assign need_erase = wr_page != r_page;
    assign full       = r_count == fwp_pkg::CNT_W'(fwp_pkg::WORD_BYTES - 1);

    always_comb begin
        w_full = '0;
        w_pad  = '0;
        for (int i = 0; i < fwp_pkg::WORD_BYTES; i++) begin
            w_full[8*i +: 8] = (i == int'(r_count)) ? i_byte : r_bytes[i];
            w_pad[8*i +: 8]  = (i < int'(r_count)) ? r_bytes[i] : fwp_pkg::BYTE_PAD;
        end
    end

    always_comb begin
        erase_res               = '0;
        erase_res.command       = fwp_pkg::CMD_ERASE;
        erase_res.flash_address = {wr_page, fwp_pkg::PAGE_W'(0)};
        erase_res.status        = fwp_pkg::ST_OK;
        prog_res                = '0;
        prog_res.command        = fwp_pkg::CMD_PROGRAM;
        prog_res.flash_address  = r_cursor;
        prog_res.word_data      = w_full;
        prog_res.status         = fwp_pkg::ST_OK;
    end

    always_comb begin
        o_res0      = '0;
        o_res1      = '0;
        o_two       = 1'b0;
        o_res0.last = 1'b1;
        o_res1.last = 1'b1;
        n_on        = r_on;
        n_cursor    = r_cursor;
        n_page      = r_page;
        n_count     = r_count;
        store       = 1'b0;
        case (i_func)
            fwp_pkg::FUNC_BEGIN: begin
                if (i_start[fwp_pkg::PAGE_W-1:0] != '0) begin
                    o_res0.status = fwp_pkg::ST_MISALIGNED;
                end else begin
                    o_res0.command       = fwp_pkg::CMD_ERASE;
                    o_res0.flash_address = i_start;
                    n_on                 = 1'b1;
                    n_cursor             = i_start;
                    n_page               = i_start[31:fwp_pkg::PAGE_W];
                    n_count              = '0;
                end
            end
            fwp_pkg::FUNC_WRITE: begin
                if (!r_on) begin
                    o_res0.status = fwp_pkg::ST_NOT_STARTED;
                end else begin
                    if (need_erase) begin
                        n_page = wr_page;
                    end
                    if (full) begin
                        n_cursor = r_cursor + 32'(fwp_pkg::WORD_BYTES);
                        n_count  = '0;
                    end else begin
                        n_count = r_count + fwp_pkg::CNT_W'(1);
                        store   = 1'b1;
                    end
                    if (need_erase && full) begin
                        o_res0      = erase_res;
                        o_res1      = prog_res;
                        o_res1.last = 1'b1;
                        o_two       = 1'b1;
                    end else if (need_erase) begin
                        o_res0 = erase_res;
                    end else if (full) begin
                        o_res0 = prog_res;
                    end
                    o_res0.last = !o_two;
                end
            end
            fwp_pkg::FUNC_FINISH: begin
                if (!r_on) begin
                    o_res0.status = fwp_pkg::ST_NOT_STARTED;
                end else begin
                    if (r_count != '0) begin
                        o_res0.command       = fwp_pkg::CMD_PROGRAM;
                        o_res0.flash_address = r_cursor;
                        o_res0.word_data     = w_pad;
                        n_cursor             = r_cursor + 32'(fwp_pkg::WORD_BYTES);
                    end
                    n_on    = 1'b0;
                    n_count = '0;
                end
            end
            default: begin
                n_on    = 1'b0;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on     <= 1'b0;
            r_cursor <= '0;
            r_page   <= '0;
            r_count  <= '0;
        end else if (i_fire) begin
            r_on     <= n_on;
            r_cursor <= n_cursor;
            r_page   <= n_page;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && store) begin
            r_bytes[r_count[fwp_pkg::IDX_W-1:0]] <= i_byte;
        end
    end

    `FWP_ASSERT(a_count_below_word, i_clk, i_rst_n,
        r_count < fwp_pkg::CNT_W'(fwp_pkg::WORD_BYTES))
    `FWP_ASSERT(a_idle_no_pending, i_clk, i_rst_n, !r_on |-> r_count == '0)
    `FWP_ASSERT_ALWAYS(a_erase_aligned, i_clk,
        o_res0.command == fwp_pkg::CMD_ERASE |->
            o_res0.flash_address[fwp_pkg::PAGE_W-1:0] == '0)

endmodule

FILE: hdl/fwp_outq.sv
// Two-entry result queue feeding the output stream.
`include "flash_write_packer_core_assert.svh"

module fwp_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic           i_two,
    input  fwp_pkg::t_res  i_res0,
    input  fwp_pkg::t_res  i_res1,
    input  logic           i_pop_ready,
    output fwp_pkg::t_room o_room,
    output logic           o_valid,
    output fwp_pkg::t_res  o_head
);

    logic [1:0]    r_cnt;
    logic [1:0]    n_cnt;
    fwp_pkg::t_res r_slot0;
    fwp_pkg::t_res r_slot1;
    fwp_pkg::t_res n_slot0;
    fwp_pkg::t_res n_slot1;
    logic          pop;
    logic [1:0]    base;

    assign o_valid = r_cnt != 2'd0;
    assign o_head  = r_slot0;
    assign pop     = o_valid && i_pop_ready;
    assign base    = r_cnt - {1'b0, pop};

    assign o_room.room_one = base != 2'd2;
    assign o_room.room_two = base == 2'd0;

    always_comb begin
        n_slot0 = pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = base;
        if (i_push) begin
            if (base == 2'd0) begin
                n_slot0 = i_res0;
                n_slot1 = i_res1;
            end else begin
                n_slot1 = i_res0;
            end
            n_cnt = base + (i_two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    `FWP_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt != 2'd3)
    `FWP_ASSERT(a_push_fits, i_clk, i_rst_n,
        i_push |-> (i_two ? base == 2'd0 : base != 2'd2))

endmodule

FILE: hdl/flash_write_packer_core.sv
// Top level of the flash write packer: input register, engine and result queue.
//
//  channel  | dir | tdata                              | tuser   | tlast
//  ---------+-----+------------------------------------+---------+------
//  s        | in  | session_base, data_byte            | func    | -
//  m        | out | flash_address, word_data, status   | command | last
//
// Each item waits in the input register until it fires; the engine then turns
// it combinationally into one or two results in the two-entry result queue.
// Items producing one result flow at one per cycle while the output does not stall;
// an erase plus a program leave as two results through the single output port.
// Reset is synchronous, active low, and leaves no session open.
// A stalled output backs up the queue, then the input register, then o_s_tready.
module flash_write_packer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [39:0]   i_s_tdata,   // [31:0] session_base, [39:32] data_byte
    input  logic [1:0]    i_s_tuser,   // [1:0] func
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [103:0]  o_m_tdata,   // [31:0] flash_address, [95:32] word_data,
                                       // [97:96] status, [103:98] zero
    output logic [1:0]    o_m_tuser,   // [1:0] command
    output logic          o_m_tlast
);

    logic           r_in_valid;
    logic [1:0]     r_func;
    logic [31:0]    r_start;
    logic [7:0]     r_byte;

    fwp_pkg::t_res  res0;
    fwp_pkg::t_res  res1;
    logic           two;
    fwp_pkg::t_room room;
    fwp_pkg::t_res  head;
    logic           fire;
    logic           take;

    assign fire       = r_in_valid && (two ? room.room_two : room.room_one);
    assign o_s_tready = !r_in_valid || fire;
    assign take       = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_func  <= i_s_tuser;
            r_start <= i_s_tdata[31:0];
            r_byte  <= i_s_tdata[39:32];
        end
    end

    fwp_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_func  (r_func),
        .i_start (r_start),
        .i_byte  (r_byte),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_two   (two)
    );

    fwp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fire),
        .i_two       (two),
        .i_res0      (res0),
        .i_res1      (res1),
        .i_pop_ready (i_m_tready),
        .o_room      (room),
        .o_valid     (o_m_tvalid),
        .o_head      (head)
    );

    assign o_m_tdata = {6'd0, head.status, head.word_data, head.flash_address};
    assign o_m_tuser = head.command;
    assign o_m_tlast = head.last;

endmodule
